// ===== src/b64le_pkg.sv =====
// Shared types, character codes and the base64 symbol map.
// No dependencies; the front, queue, back and top files import this package.
`default_nettype none
package b64le_pkg;

    localparam logic [7:0] PAD_CHAR        = 8'h3D;
    localparam logic [7:0] CR_CHAR         = 8'h0D;
    localparam logic [7:0] LF_CHAR         = 8'h0A;
    localparam logic [7:0] GPL_RESET       = 8'd20;
    localparam logic [2:0] LAST_GROUP_CHAR = 3'd3;
    localparam logic [2:0] LAST_LINE_CHAR  = 3'd5;

    // One encoded group as handed from the front to the back.
    typedef struct packed {
        logic [3:0][5:0] idx;   // idx[0] is the first character
        logic            pad2;  // third character is '='
        logic            pad3;  // fourth character is '='
        logic            crlf;  // line break follows the group
    } group_t;

    // Standard alphabet: A-Z a-z 0-9 + /
    function automatic logic [7:0] b64_sym(input logic [5:0] v);
        logic [7:0] r;
        if (v < 6'd26)
            r = 8'h41 + {2'b00, v};
        else if (v < 6'd52)
            r = 8'h61 + {2'b00, v - 6'd26};
        else if (v < 6'd62)
            r = 8'h30 + {2'b00, v - 6'd52};
        else if (v == 6'd62)
            r = 8'h2B;
        else
            r = 8'h2F;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/b64le_if.sv =====
// Channel interfaces: byte input, character output, config write.
// No dependencies.
`default_nettype none
interface b64le_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;
    modport source (output valid, data_byte, final_byte, input ready);
    modport sink   (input valid, data_byte, final_byte, output ready);
endinterface

interface b64le_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       run_end;
    modport source (output valid, out_char, run_end, input ready);
    modport sink   (input valid, out_char, run_end, output ready);
endinterface

interface b64le_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== src/b64le_front.sv =====
// Front end: gathers bytes into groups, computes symbol indices, padding
// and line breaks. Depends on b64le_pkg.
`default_nettype none
module b64le_front
    import b64le_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       final_byte,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_data,
    output logic            q_valid,
    input  wire logic       q_ready,
    output group_t          q_data
);

    logic [15:0] pend_reg, pend_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [7:0]  line_reg, line_next;
    logic [7:0]  gpl_reg;
    logic [1:0]  cnt_eff;
    logic        accept, complete;
    logic [7:0]  b0, b1, b2, line_inc;

    assign in_ready = q_ready;
    assign accept   = in_valid && in_ready;
    assign cnt_eff  = (cnt_reg == 2'd3) ? 2'd2 : cnt_reg;
    assign complete = final_byte || (cnt_eff == 2'd2);
    assign line_inc = line_reg + 8'd1;

    always_comb
    begin
        case (cnt_eff)
            2'd0:
            begin
                b0 = data_byte; b1 = 8'd0; b2 = 8'd0;
            end
            2'd1:
            begin
                b0 = pend_reg[15:8]; b1 = data_byte; b2 = 8'd0;
            end
            default:
            begin
                b0 = pend_reg[15:8]; b1 = pend_reg[7:0]; b2 = data_byte;
            end
        endcase
    end

    always_comb
    begin
        q_data.idx[0] = b0[7:2];
        q_data.idx[1] = {b0[1:0], b1[7:4]};
        q_data.idx[2] = {b1[3:0], b2[7:6]};
        q_data.idx[3] = b2[5:0];
        q_data.pad2   = (cnt_eff == 2'd0);
        q_data.pad3   = (cnt_eff != 2'd2);
        q_data.crlf   = (line_inc >= gpl_reg) || final_byte;
    end

    assign q_valid = in_valid && complete;

    always_comb
    begin
        pend_next = pend_reg;
        cnt_next  = cnt_reg;
        line_next = line_reg;
        if (accept)
        begin
            if (!complete)
            begin
                if (cnt_eff == 2'd0)
                    pend_next = {data_byte, 8'd0};
                else
                    pend_next = {pend_reg[15:8], data_byte};
                cnt_next = cnt_eff + 2'd1;
            end
            else
            begin
                pend_next = 16'd0;
                cnt_next  = 2'd0;
                line_next = q_data.crlf ? 8'd0 : line_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 16'd0;
            cnt_reg  <= 2'd0;
            line_reg <= 8'd0;
            gpl_reg  <= GPL_RESET;
        end
        else
        begin
            pend_reg <= pend_next;
            cnt_reg  <= cnt_next;
            line_reg <= line_next;
            if (cfg_we)
                gpl_reg <= cfg_data;
        end
    end

endmodule
`default_nettype wire

// ===== src/b64le_queue.sv =====
// Short group queue between front and back ends.
// Depends on b64le_pkg.
`default_nettype none
module b64le_queue
    import b64le_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    wr_valid,
    output logic         wr_ready,
    input  wire group_t  wr_data,
    output logic         rd_valid,
    input  wire logic    rd_ready,
    output group_t       rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    group_t          mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   cnt_reg;
    logic            push, pop;

    assign wr_ready = (cnt_reg != CNT_FULL);
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule
`default_nettype wire

// ===== src/b64le_back.sv =====
// Back end: serializes one group into characters, one per cycle while
// out_ready allows, into an output register. Depends on b64le_pkg.
`default_nettype none
module b64le_back
    import b64le_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   q_valid,
    output logic        q_ready,
    input  wire group_t q_data,
    output logic        out_valid,
    input  wire logic   out_ready,
    output logic [7:0]  out_char,
    output logic        out_run_end
);

    group_t      grp_reg;
    logic [2:0]  idx_reg;
    logic        busy_reg;
    logic        oval_reg;
    logic [7:0]  char_reg;
    logic        end_reg;
    logic        advance, last;
    logic [7:0]  ch;

    assign last    = grp_reg.crlf ? (idx_reg == LAST_LINE_CHAR)
                                  : (idx_reg == LAST_GROUP_CHAR);
    assign advance = busy_reg && (!oval_reg || out_ready);
    assign q_ready = !busy_reg || (advance && last);

    always_comb
    begin
        case (idx_reg)
            3'd0:    ch = b64_sym(grp_reg.idx[0]);
            3'd1:    ch = b64_sym(grp_reg.idx[1]);
            3'd2:    ch = grp_reg.pad2 ? PAD_CHAR : b64_sym(grp_reg.idx[2]);
            3'd3:    ch = grp_reg.pad3 ? PAD_CHAR : b64_sym(grp_reg.idx[3]);
            3'd4:    ch = CR_CHAR;
            default: ch = LF_CHAR;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready)
            grp_reg <= q_data;
        if (advance)
        begin
            char_reg <= ch;
            end_reg  <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 3'd0;
            oval_reg <= 1'b0;
        end
        else
        begin
            if (q_valid && q_ready)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= 3'd0;
            end
            else if (advance)
            begin
                if (last)
                    busy_reg <= 1'b0;
                idx_reg <= idx_reg + 3'd1;
            end
            if (advance)
                oval_reg <= 1'b1;
            else if (out_ready)
                oval_reg <= 1'b0;
        end
    end

    assign out_valid   = oval_reg;
    assign out_char    = char_reg;
    assign out_run_end = end_reg;

endmodule
`default_nettype wire

// ===== src/base64_line_encoder_unit.sv =====
// Top level of the base64 line encoder: front end, group queue, back end.
// Depends on b64le_pkg, b64le_if, b64le_front, b64le_queue, b64le_back.
`default_nettype none
// Base64 encoder with CR LF line wrap. Bytes arrive on byte_in, final_byte
// marking the last byte of a message. Every third byte (or the final one)
// yields four base64 characters on char_out, '=' padded for a short final
// group, followed by CR LF once groups_per_line groups sit on the line and
// always after the final group. run_end flags the last character caused by
// a byte. Throughput: a byte is taken each cycle while the group queue has
// room; the back end writes one character per cycle while char_out is
// ready, via a single-character output register. A completing byte's group
// passes through the queue, the back end's group register and the output
// register. groups_per_line (reset 20) must be written on cfg while idle;
// this is not enforced. A value of zero breaks after every group.
module base64_line_encoder_unit
    import b64le_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    b64le_byte_if.sink   byte_in,
    b64le_char_if.source char_out,
    b64le_cfg_if.sink    cfg
);

    // front -> queue request
    logic   fq_valid, fq_ready;
    group_t fq_data;
    // queue -> back request
    logic   qb_valid, qb_ready;
    group_t qb_data;

    // the user must write config only while idle; the block does not enforce this, so cfg is always accepted
    assign cfg.ready = 1'b1;

    b64le_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (byte_in.valid),
        .in_ready   (byte_in.ready),
        .data_byte  (byte_in.data_byte),
        .final_byte (byte_in.final_byte),
        .cfg_we     (cfg.valid),
        .cfg_data   (cfg.data),
        .q_valid    (fq_valid),
        .q_ready    (fq_ready),
        .q_data     (fq_data)
    );

    b64le_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    b64le_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (qb_valid),
        .q_ready     (qb_ready),
        .q_data      (qb_data),
        .out_valid   (char_out.valid),
        .out_ready   (char_out.ready),
        .out_char    (char_out.out_char),
        .out_run_end (char_out.run_end)
    );

endmodule
`default_nettype wire
